>>> rtl/csp_pkg.sv
// ----------------------------------------------------------------------------
// Command stream password generator package
// Shared types, header codes and the bit permutation of the password value.
// ----------------------------------------------------------------------------
package csp_pkg;

   localparam int WORD_BITS = 16;
   localparam int SALT_BITS = 15;
   localparam int DATA_BITS = 48;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [WORD_BITS-1:0] HDR_PASSWORD = 16'hFE04;
   localparam logic [WORD_BITS-1:0] HDR_END = 16'h0001;
   localparam logic [WORD_BITS-1:0] HDR_NONE = 16'h0000;
   localparam logic [WORD_BITS-1:0] LEN_MASK = 16'h00FF;

   // Register index, taken from the word address of the control port.
   localparam logic REG_SALT = 1'b0;

   typedef enum logic [1:0] {
      MODE_SEARCH = 2'd0,
      MODE_SLOTS = 2'd1,
      MODE_TAIL = 2'd2,
      MODE_STOP = 2'd3
   } mode_type;

   typedef struct packed {
      logic found;
      logic [WORD_BITS-1:0] bytes;
      logic [WORD_BITS-1:0] sum;
   } walk_result_type;

   // Destination bit of each source bit of the 48-bit password value.
   localparam logic [5:0] PERM [DATA_BITS] = '{
      6'h15, 6'h0F, 6'h25, 6'h21, 6'h1B, 6'h16, 6'h09, 6'h24,
      6'h07, 6'h2E, 6'h26, 6'h14, 6'h28, 6'h0D, 6'h0A, 6'h20,
      6'h10, 6'h01, 6'h02, 6'h1A, 6'h13, 6'h11, 6'h06, 6'h08,
      6'h2D, 6'h17, 6'h2B, 6'h0E, 6'h00, 6'h1E, 6'h12, 6'h19,
      6'h05, 6'h22, 6'h18, 6'h2F, 6'h0C, 6'h1D, 6'h1F, 6'h27,
      6'h03, 6'h04, 6'h23, 6'h2C, 6'h1C, 6'h2A, 6'h29, 6'h0B
   };

   function automatic logic [DATA_BITS-1:0] permute48(input logic [DATA_BITS-1:0] data);
      logic [DATA_BITS-1:0] result;
      result = '0;
      for (int k = 0; k < DATA_BITS; k++) begin
         result[PERM[k]] = data[k];
      end
      return result;
   endfunction

endpackage

>>> rtl/csp_csr.sv
// ----------------------------------------------------------------------------
// Control register port
// Holds the salt register behind a simple two-phase register bus.
// ----------------------------------------------------------------------------
module csp_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [csp_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [csp_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [csp_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                csr_pready,
   output logic [csp_pkg::SALT_BITS-1:0]       salt
);
   import csp_pkg::*;

   logic [SALT_BITS-1:0] salt_ff;
   logic [SALT_BITS-1:0] salt_in;
   logic                 wr_salt;

   assign csr_pready = 1'b1;
   assign wr_salt = csr_psel && csr_penable && csr_pwrite && csr_pready
                    && (csr_paddr[2] == REG_SALT);
   assign salt_in = wr_salt ? csr_pwdata[SALT_BITS-1:0] : salt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         salt_ff <= '0;
      end else begin
         salt_ff <= salt_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == REG_SALT) begin
         csr_prdata = {{(CSR_DATA_BITS-SALT_BITS){1'b0}}, salt_ff};
      end
   end

   assign salt = salt_ff;

endmodule

>>> rtl/csp_walker.sv
// ----------------------------------------------------------------------------
// Command header walker
// Follows the header chain, finds the password command and sums its tail.
// ----------------------------------------------------------------------------
module csp_walker #(
   parameter int POSITION_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              step,
   input  logic [csp_pkg::WORD_BITS-1:0]     word,
   input  logic                              last,
   output csp_pkg::walk_result_type          result
);
   import csp_pkg::*;

   logic [POSITION_BITS-1:0] position_ff, position_in;
   logic [POSITION_BITS-1:0] next_header_ff, next_header_in, next_header_upd;
   logic [POSITION_BITS-1:0] tail_start_ff, tail_start_in, tail_start_upd;
   mode_type                 mode_ff, mode_in, mode_upd;
   logic [WORD_BITS-1:0]     sum_ff, sum_in, sum_upd;
   logic [WORD_BITS-2:0]     count_ff, count_in, count_upd;
   logic                     at_header;
   logic                     at_tail;
   logic                     stop_header;
   logic                     take;
   logic                     found;

   assign at_header = position_ff == next_header_ff;
   assign at_tail = position_ff == tail_start_ff;
   assign stop_header = (word == HDR_NONE) || (word == HDR_END)
                        || ((word & LEN_MASK) == HDR_NONE);

   // Walk mode after this word.
   always_comb begin
      mode_upd = mode_ff;
      case (mode_ff)
         MODE_SEARCH: begin
            if (at_header) begin
               if (word == HDR_PASSWORD) begin
                  mode_upd = MODE_SLOTS;
               end else if (stop_header) begin
                  mode_upd = MODE_STOP;
               end
            end
         end
         MODE_SLOTS: begin
            if (at_tail) begin
               mode_upd = MODE_TAIL;
            end
         end
         default: begin
            mode_upd = mode_ff;
         end
      endcase
   end

   always_comb begin
      take = (mode_ff == MODE_TAIL) || ((mode_ff == MODE_SLOTS) && at_tail);
      tail_start_upd = tail_start_ff;
      next_header_upd = next_header_ff;
      if ((mode_ff == MODE_SEARCH) && at_header) begin
         if (word == HDR_PASSWORD) begin
            tail_start_upd = position_ff + POSITION_BITS'(4);
         end else if (!stop_header) begin
            next_header_upd = position_ff + POSITION_BITS'(word & LEN_MASK);
         end
      end
      // Checksum: rotate left by one, then add the tail word.
      sum_upd = take ? ({sum_ff[WORD_BITS-2:0], sum_ff[WORD_BITS-1]} + word) : sum_ff;
      count_upd = take ? (count_ff + (WORD_BITS-1)'(1)) : count_ff;

      // An empty tail still counts when the stream ends just before it.
      found = (mode_upd == MODE_TAIL)
              || ((mode_upd == MODE_SLOTS)
                  && ((position_ff + POSITION_BITS'(1)) == tail_start_upd));

      result.found = found;
      result.bytes = found ? {count_upd, 1'b0} : '0;
      result.sum = found ? sum_upd : '0;

      if (last) begin
         position_in = '0;
         next_header_in = '0;
         tail_start_in = '0;
         mode_in = MODE_SEARCH;
         sum_in = '0;
         count_in = '0;
      end else begin
         position_in = position_ff + POSITION_BITS'(1);
         next_header_in = next_header_upd;
         tail_start_in = tail_start_upd;
         mode_in = mode_upd;
         sum_in = sum_upd;
         count_in = count_upd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff <= '0;
         next_header_ff <= '0;
         tail_start_ff <= '0;
         mode_ff <= MODE_SEARCH;
         sum_ff <= '0;
         count_ff <= '0;
      end else if (step) begin
         position_ff <= position_in;
         next_header_ff <= next_header_in;
         tail_start_ff <= tail_start_in;
         mode_ff <= mode_in;
         sum_ff <= sum_in;
         count_ff <= count_in;
      end
   end

endmodule

>>> rtl/csp_permute.sv
// ----------------------------------------------------------------------------
// Password permutation
// Packs salt, byte count and checksum and scatters the bits into three words.
// ----------------------------------------------------------------------------
module csp_permute (
   input  csp_pkg::walk_result_type          result,
   input  logic [csp_pkg::SALT_BITS-1:0]     salt,
   output logic [csp_pkg::WORD_BITS-1:0]     slot_one,
   output logic [csp_pkg::WORD_BITS-1:0]     slot_two,
   output logic [csp_pkg::WORD_BITS-1:0]     slot_three
);
   import csp_pkg::*;

   logic [DATA_BITS-1:0] data;
   logic [DATA_BITS-1:0] scrambled;

   assign data = {result.sum, result.bytes, 1'b0, salt};
   assign scrambled = permute48(data);

   assign slot_one = result.found ? scrambled[47:32] : '0;
   assign slot_two = result.found ? scrambled[31:16] : '0;
   assign slot_three = result.found ? scrambled[15:0] : '0;

endmodule

>>> rtl/command_stream_password_generator.sv
// ----------------------------------------------------------------------------
// Command stream password generator: one word per cycle while the result side
// does not stall. Words wait in the input register; the result register is
// loaded when the last word leaves it. Reset clears all stream state and salt.
// ----------------------------------------------------------------------------
module command_stream_password_generator #(
   parameter int POSITION_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [csp_pkg::WORD_BITS-1:0]       req_word,
   input  logic                                req_last,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_found,
   output logic [csp_pkg::WORD_BITS-1:0]       rsp_slot_one,
   output logic [csp_pkg::WORD_BITS-1:0]       rsp_slot_two,
   output logic [csp_pkg::WORD_BITS-1:0]       rsp_slot_three,
   output logic [csp_pkg::WORD_BITS-1:0]       rsp_tail_bytes,
   output logic [csp_pkg::WORD_BITS-1:0]       rsp_tail_sum,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [csp_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [csp_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [csp_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                csr_pready
);
   import csp_pkg::*;

   logic                 in_valid_ff, in_valid_in;
   logic [WORD_BITS-1:0] in_word_ff;
   logic                 in_last_ff;
   logic                 accept;
   logic                 out_free;
   logic                 fire;
   logic                 load_rsp;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_found_ff;
   logic [WORD_BITS-1:0] rsp_slot_one_ff, rsp_slot_two_ff, rsp_slot_three_ff;
   logic [WORD_BITS-1:0] rsp_tail_bytes_ff, rsp_tail_sum_ff;

   logic [SALT_BITS-1:0] salt;
   walk_result_type      walk_result;
   logic [WORD_BITS-1:0] slot_one, slot_two, slot_three;

   csp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .salt        (salt)
   );

   // A word that ends a stream moves on only when the result register is free.
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign fire = in_valid_ff && (!in_last_ff || out_free);
   assign load_rsp = fire && in_last_ff;
   assign req_stall = in_valid_ff && !fire;
   assign accept = req_valid && !req_stall;
   assign in_valid_in = accept || (in_valid_ff && !fire);
   assign rsp_valid_in = load_rsp || (rsp_valid_ff && rsp_stall);

   csp_walker #(
      .POSITION_BITS (POSITION_BITS)
   ) u_walker (
      .clock  (clock),
      .reset  (reset),
      .step   (fire),
      .word   (in_word_ff),
      .last   (in_last_ff),
      .result (walk_result)
   );

   csp_permute u_permute (
      .result     (walk_result),
      .salt       (salt),
      .slot_one   (slot_one),
      .slot_two   (slot_two),
      .slot_three (slot_three)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_word_ff <= req_word;
         in_last_ff <= req_last;
      end
      if (load_rsp) begin
         rsp_found_ff <= walk_result.found;
         rsp_slot_one_ff <= slot_one;
         rsp_slot_two_ff <= slot_two;
         rsp_slot_three_ff <= slot_three;
         rsp_tail_bytes_ff <= walk_result.bytes;
         rsp_tail_sum_ff <= walk_result.sum;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_found = rsp_found_ff;
   assign rsp_slot_one = rsp_slot_one_ff;
   assign rsp_slot_two = rsp_slot_two_ff;
   assign rsp_slot_three = rsp_slot_three_ff;
   assign rsp_tail_bytes = rsp_tail_bytes_ff;
   assign rsp_tail_sum = rsp_tail_sum_ff;

   a_stall_needs_word: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> !req_stall)
      else $error("input stalled with an empty input register");

   a_last_gives_result: assert property (@(posedge clock) disable iff (reset)
      load_rsp |=> rsp_valid)
      else $error("last word did not produce a result transfer");

   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |-> (rsp_slot_one == '0 && rsp_slot_two == '0
         && rsp_slot_three == '0 && rsp_tail_bytes == '0 && rsp_tail_sum == '0))
      else $error("result without password carries nonzero fields");

   a_even_bytes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !rsp_tail_bytes[0])
      else $error("tail byte count is odd");

endmodule

>>> tb/command_stream_password_generator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Command stream password generator testbench
// Feeds command streams word by word: a short table of directed streams, then
// random streams, mostly well-formed with a password command and a tail.
// Between phases the salt changes. A header walk model predicts each result
// not fixed by the table. Both sides of the block idle and stall at random.
// ----------------------------------------------------------------------------
module command_stream_password_generator_tb;
   import csp_pkg::*;

   localparam int POS_BITS = 16;
   localparam int LIMIT_CYCLES = 400000;
   localparam int PHASES = 7;
   localparam int PHASE_WORDS = 95;
   localparam logic [CSR_ADDR_BITS-1:0] SALT_ADDR = {REG_SALT, 2'b00};

   // Destination bit of each source bit of the 48-bit password value.
   localparam byte unsigned BIT_DEST [48] = '{
      8'h15, 8'h0F, 8'h25, 8'h21, 8'h1B, 8'h16, 8'h09, 8'h24,
      8'h07, 8'h2E, 8'h26, 8'h14, 8'h28, 8'h0D, 8'h0A, 8'h20,
      8'h10, 8'h01, 8'h02, 8'h1A, 8'h13, 8'h11, 8'h06, 8'h08,
      8'h2D, 8'h17, 8'h2B, 8'h0E, 8'h00, 8'h1E, 8'h12, 8'h19,
      8'h05, 8'h22, 8'h18, 8'h2F, 8'h0C, 8'h1D, 8'h1F, 8'h27,
      8'h03, 8'h04, 8'h23, 8'h2C, 8'h1C, 8'h2A, 8'h29, 8'h0B
   };

   typedef struct packed {
      logic found;
      logic [WORD_BITS-1:0] slot_one;
      logic [WORD_BITS-1:0] slot_two;
      logic [WORD_BITS-1:0] slot_three;
      logic [WORD_BITS-1:0] tail_bytes;
      logic [WORD_BITS-1:0] tail_sum;
   } password_type;

   typedef struct packed {
      logic [WORD_BITS-1:0] word;
      logic last;
      logic fixed;
      password_type want;
   } stream_row_type;

   localparam password_type NO_PASSWORD = '0;
   // Password command with an empty tail while the salt is still zero.
   localparam password_type BARE_PASSWORD = '{found: 1'b1, default: '0};

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic [WORD_BITS-1:0] req_word;
   logic req_last;
   logic rsp_valid;
   logic rsp_stall;
   logic rsp_found;
   logic [WORD_BITS-1:0] rsp_slot_one;
   logic [WORD_BITS-1:0] rsp_slot_two;
   logic [WORD_BITS-1:0] rsp_slot_three;
   logic [WORD_BITS-1:0] rsp_tail_bytes;
   logic [WORD_BITS-1:0] rsp_tail_sum;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [CSR_ADDR_BITS-1:0] csr_paddr;
   logic [CSR_DATA_BITS-1:0] csr_pwdata;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic csr_pready;

   // Walk state of the predictor.
   logic [POS_BITS-1:0] word_pos;
   logic [POS_BITS-1:0] next_hdr;
   logic [POS_BITS-1:0] tail_pos;
   mode_type walk_mode;
   logic [16:0] check_sum;
   logic [WORD_BITS-1:0] tail_words;
   logic [SALT_BITS-1:0] salt_reg;

   password_type pending_passwords [$];
   logic [WORD_BITS-1:0] stream_words [$];
   stream_row_type directed_rows [25];
   int error_count;
   int cycle_count;
   bit req_steady;
   bit rsp_steady;

   command_stream_password_generator #(
      .POSITION_BITS(POS_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_word(req_word),
      .req_last(req_last),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_found(rsp_found),
      .rsp_slot_one(rsp_slot_one),
      .rsp_slot_two(rsp_slot_two),
      .rsp_slot_three(rsp_slot_three),
      .rsp_tail_bytes(rsp_tail_bytes),
      .rsp_tail_sum(rsp_tail_sum),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic int draw_wait(inout bit steady);
      if ($urandom_range(0, 24) == 0) steady = !steady;
      return steady ? 0 : int'($urandom_range(0, 19));
   endfunction

   function automatic logic [WORD_BITS-1:0] rand_word();
      case ($urandom_range(0, 7))
         0: return '1;
         1: return '0;
         default: return WORD_BITS'($urandom);
      endcase
   endfunction

   function automatic logic [47:0] scramble(input logic [47:0] data);
      logic [47:0] pw;
      pw = '0;
      for (int k = 0; k < 48; k++) begin
         if (data[k]) pw[BIT_DEST[k]] = 1'b1;
      end
      return pw;
   endfunction

   function automatic void clear_walk();
      word_pos = '0;
      next_hdr = '0;
      tail_pos = '0;
      walk_mode = MODE_SEARCH;
      check_sum = '0;
      tail_words = '0;
   endfunction

   // Rotate the 16-bit sum left by one, then add the word.
   function automatic void add_tail_word(input logic [WORD_BITS-1:0] w);
      check_sum = {1'b0, check_sum[14:0], check_sum[15]} + 17'(w);
      tail_words = tail_words + WORD_BITS'(1);
   endfunction

   // Advances the header walk by one word; on the last word it returns the
   // password the block should report for the stream.
   function automatic bit track_word(input logic [WORD_BITS-1:0] w, input logic l,
                                     output password_type res);
      logic [POS_BITS-1:0] after_pos;
      logic [WORD_BITS-1:0] bytes;
      logic [47:0] pw;
      res = NO_PASSWORD;
      case (walk_mode)
         MODE_SEARCH: begin
            if (word_pos == next_hdr) begin
               if (w == HDR_PASSWORD) begin
                  walk_mode = MODE_SLOTS;
                  tail_pos = word_pos + POS_BITS'(4);
               end else if (w == HDR_NONE || w == HDR_END || (w & LEN_MASK) == '0) begin
                  walk_mode = MODE_STOP;
               end else begin
                  next_hdr = word_pos + POS_BITS'(w & LEN_MASK);
               end
            end
         end
         MODE_SLOTS: begin
            if (word_pos == tail_pos) begin
               walk_mode = MODE_TAIL;
               add_tail_word(w);
            end
         end
         MODE_TAIL: add_tail_word(w);
         default: ;
      endcase
      after_pos = word_pos + POS_BITS'(1);
      if (!l) begin
         word_pos = after_pos;
         return 1'b0;
      end
      // An empty tail still counts once the stream reaches the tail position.
      if (walk_mode == MODE_TAIL || (walk_mode == MODE_SLOTS && after_pos == tail_pos)) begin
         bytes = {tail_words[14:0], 1'b0};
         pw = scramble({check_sum[15:0], bytes, 1'b0, salt_reg});
         res.found = 1'b1;
         res.slot_one = pw[47:32];
         res.slot_two = pw[31:16];
         res.slot_three = pw[15:0];
         res.tail_bytes = bytes;
         res.tail_sum = check_sum[15:0];
      end
      clear_walk();
      return 1'b1;
   endfunction

   // Entered and left at a falling edge.
   task automatic send_word(input logic [WORD_BITS-1:0] w, input logic l, input bit fixed,
                            input password_type want);
      int gap;
      password_type predicted;
      gap = draw_wait(req_steady);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_word <= w;
      req_last <= l;
      do @(posedge clock); while (req_stall !== 1'b0);
      if (track_word(w, l, predicted)) pending_passwords.push_back(fixed ? want : predicted);
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_passwords.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_salt(input logic [SALT_BITS-1:0] value);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= SALT_ADDR;
      csr_pwdata <= CSR_DATA_BITS'(value);
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      salt_reg = value;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   function automatic void build_stream();
      int roll;
      int len;
      int keep;
      logic [WORD_BITS-1:0] hdr;
      stream_words.delete();
      roll = $urandom_range(0, 99);
      if (roll < 80) begin
         repeat ($urandom_range(0, 3)) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
            do hdr = {8'($urandom), 8'(len)};
            while (hdr == HDR_PASSWORD || hdr == HDR_END);
            stream_words.push_back(hdr);
            repeat (len - 1) stream_words.push_back(rand_word());
         end
         stream_words.push_back(HDR_PASSWORD);
         repeat (3) stream_words.push_back(rand_word());
         len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12);
         repeat (len) stream_words.push_back(rand_word());
         // Some streams break off early, often before the tail.
         if (roll < 10) begin
            keep = $urandom_range(1, stream_words.size());
            while (stream_words.size() > keep) void'(stream_words.pop_back());
         end
      end else begin
         case ($urandom_range(0, 4))
            0: stream_words.push_back(HDR_NONE);
            1: stream_words.push_back(HDR_END);
            2: stream_words.push_back({8'($urandom), 8'h00});
            3: stream_words.push_back(HDR_PASSWORD);
            default: stream_words.push_back(rand_word());
         endcase
         repeat ($urandom_range(0, 10)) stream_words.push_back(rand_word());
      end
   endfunction

   function automatic void compare_field(input string what, input logic [WORD_BITS-1:0] want,
                                         input logic [WORD_BITS-1:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %h, got %h", $time, what, want, got);
         error_count++;
      end
   endfunction

   // Result side: stalls at random, then checks each transfer in order.
   initial begin
      password_type want;
      rsp_stall = 1'b0;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         int gap;
         gap = draw_wait(rsp_steady);
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         if (pending_passwords.size() == 0) begin
            $display("%0t: result with no expectation, found %b sum %h", $time, rsp_found,
                     rsp_tail_sum);
            error_count++;
         end else begin
            want = pending_passwords.pop_front();
            compare_field("found", 16'(want.found), 16'(rsp_found));
            compare_field("slot_one", want.slot_one, rsp_slot_one);
            compare_field("slot_two", want.slot_two, rsp_slot_two);
            compare_field("slot_three", want.slot_three, rsp_slot_three);
            compare_field("tail_bytes", want.tail_bytes, rsp_tail_bytes);
            compare_field("tail_sum", want.tail_sum, rsp_tail_sum);
         end
         @(negedge clock);
      end
   end

   initial begin
      int phase_words;
      reset = 1'b1;
      req_valid = 1'b0;
      req_word = '0;
      req_last = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      error_count = 0;
      cycle_count = 0;
      req_steady = 1'b0;
      rsp_steady = 1'b0;
      salt_reg = '0;
      clear_walk();

      // Streams at the reset salt of zero: terminators, empty tail, short tail,
      // zero length header, a walk over two commands, header past the end.
      directed_rows = '{
         '{16'h0000, 1'b1, 1'b1, NO_PASSWORD},
         '{16'h0001, 1'b1, 1'b1, NO_PASSWORD},
         '{16'hFE04, 1'b0, 1'b0, NO_PASSWORD},
         '{16'hFFFF, 1'b0, 1'b0, NO_PASSWORD},
         '{16'h0000, 1'b0, 1'b0, NO_PASSWORD},
         '{16'hAAAA, 1'b1, 1'b1, BARE_PASSWORD},
         '{16'hFE04, 1'b0, 1'b0, NO_PASSWORD},
         '{16'h0001, 1'b0, 1'b0, NO_PASSWORD},
         '{16'h0002, 1'b0, 1'b0, NO_PASSWORD},
         '{16'h0003, 1'b0, 1'b0, NO_PASSWORD},
         '{16'hFFFF, 1'b1, 1'b0, NO_PASSWORD},
         '{16'h0100, 1'b0, 1'b0, NO_PASSWORD},
         '{16'h0000, 1'b1, 1'b1, NO_PASSWORD},
         '{16'h0003, 1'b0, 1'b0, NO_PASSWORD},
         '{16'hFE04, 1'b0, 1'b0, NO_PASSWORD},
         '{16'h1234, 1'b0, 1'b0, NO_PASSWORD},
         '{16'h0202, 1'b0, 1'b0, NO_PASSWORD},
         '{16'hFFFF, 1'b0, 1'b0, NO_PASSWORD},
         '{16'hFE04, 1'b0, 1'b0, NO_PASSWORD},
         '{16'h8001, 1'b0, 1'b0, NO_PASSWORD},
         '{16'h7FFE, 1'b0, 1'b0, NO_PASSWORD},
         '{16'h5555, 1'b0, 1'b0, NO_PASSWORD},
         '{16'hC3A5, 1'b1, 1'b0, NO_PASSWORD},
         '{16'h00FF, 1'b0, 1'b0, NO_PASSWORD},
         '{16'h0001, 1'b1, 1'b1, NO_PASSWORD}
      };

      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i]) begin
         send_word(directed_rows[i].word, directed_rows[i].last, directed_rows[i].fixed,
                   directed_rows[i].want);
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         drain_results();
         case (phase)
            0: write_salt(15'd32766);
            1: write_salt(15'd0);
            2: write_salt(15'd1);
            default: write_salt(SALT_BITS'($urandom_range(0, 32766)));
         endcase
         phase_words = 0;
         while (phase_words < PHASE_WORDS) begin
            build_stream();
            foreach (stream_words[i]) begin
               send_word(stream_words[i], i == stream_words.size() - 1, 1'b0, NO_PASSWORD);
            end
            phase_words += stream_words.size();
         end
      end

      drain_results();
      repeat (10) @(negedge clock);
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/csp_pkg.sv
rtl/csp_csr.sv
rtl/csp_walker.sv
rtl/csp_permute.sv
rtl/command_stream_password_generator.sv
tb/command_stream_password_generator_tb.sv
